>>> rtl/isa_pkg.sv
`timescale 1ns / 1ps
package isa_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int VALUE_W_DEF = 32;
    // match vector is priority encoded in groups of this size
    localparam int GROUP_N     = 16;

    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_REMOVE_AT  = 3'd1,
        OP_REMOVE_VAL = 3'd2,
        OP_FIND       = 3'd3,
        OP_READ       = 3'd4,
        OP_WRITE      = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_POP        = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_RANGE   = 3'd1,
        STS_FULL    = 3'd2,
        STS_MISSING = 3'd3,
        STS_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_WR   = 2'd3
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SRCH = 2'd2,
        ST_FIN  = 2'd3
    } t_state;

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  index;
        logic [4:0]  total;
        t_status     status;
    } t_result;

endpackage

>>> rtl/indexed_shift_array_top.sv
`timescale 1ns / 1ps
// channel   | dir | handshake                      | payload
// s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready| tdata[39:0]: operation, position, new_value
// m_axis    | out | o_m_axis_tvalid/i_m_axis_tready| tdata[47:0]: result_value, result_index,
//           |     |                                |   entry_total, status
//
// an item is latched while idle and executed in the execute state; no new item is taken until
// the block is idle again. find and remove-by-value also pass the search and finish states,
// waiting on the two-stage registered priority encoder over the cell match bits
// a result held on m_axis stalls execution but the next item is still latched
// i_rst_n clears the live count and the control state; cell contents are not reset
module indexed_shift_array_top #(
    parameter int DEPTH       = isa_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = isa_pkg::VALUE_W_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // operation[2:0], position[7:3], new_value[39:8]
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // result_value[31:0], result_index[35:32], entry_total[40:36], status[43:41], zero pad
    output logic [47:0] o_m_axis_tdata
);
    import isa_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [VALUE_WIDTH-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]       w_match;
    logic [DEPTH-1:0]       w_live;
    t_cell_op               w_cell_op;
    logic [IDX_W-1:0]       w_cell_pos;
    logic [VALUE_WIDTH-1:0] w_key;
    logic                   w_found;
    logic [IDX_W-1:0]       w_fidx;
    t_result                w_res;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[i+1];
        end
        isa_cell #(
            .VALUE_WIDTH(VALUE_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (i)
        ) u_cell (
            .i_clk  (i_clk),
            .i_op   (w_cell_op),
            .i_pos  (w_cell_pos),
            .i_key  (w_key),
            .i_left (w_left),
            .i_right(w_right),
            .o_data (w_data[i]),
            .o_match(w_match[i])
        );
    end

    isa_ffs #(
        .DEPTH(DEPTH),
        .IDX_W(IDX_W)
    ) u_ffs (
        .i_clk  (i_clk),
        .i_match(w_match & w_live),
        .o_found(w_found),
        .o_index(w_fidx)
    );

    isa_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_op      (t_op'(i_s_axis_tdata[2:0])),
        .i_pos     (i_s_axis_tdata[7:3]),
        .i_val     (i_s_axis_tdata[39:8]),
        .i_data    (w_data),
        .i_found   (w_found),
        .i_fidx    (w_fidx),
        .o_live    (w_live),
        .o_cell_op (w_cell_op),
        .o_cell_pos(w_cell_pos),
        .o_key     (w_key),
        .o_ovalid  (o_m_axis_tvalid),
        .i_oready  (i_m_axis_tready),
        .o_result  (w_res)
    );

    assign o_m_axis_tdata = {4'b0, w_res.status, w_res.total, w_res.index, w_res.value};

endmodule

>>> rtl/isa_cell.sv
`timescale 1ns / 1ps
module isa_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int IDX_W       = 4,
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  isa_pkg::t_cell_op      i_op,
    input  logic [IDX_W-1:0]       i_pos,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    output logic [VALUE_WIDTH-1:0] o_data,
    output logic                   o_match
);
    import isa_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [VALUE_WIDTH-1:0] r_data;
    logic [VALUE_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_op)
            CELL_INS: begin
                if (MY_IDX == i_pos) begin
                    n_data = i_key;
                end else if (MY_IDX > i_pos) begin
                    n_data = i_left;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= i_pos) begin
                    n_data = i_right;
                end
            end
            CELL_WR: begin
                if (MY_IDX == i_pos) begin
                    n_data = i_key;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

>>> rtl/isa_ffs.sv
`timescale 1ns / 1ps
module isa_ffs #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic [DEPTH-1:0] i_match,
    output logic             o_found,
    output logic [IDX_W-1:0] o_index
);
    import isa_pkg::*;

    localparam int NG    = (DEPTH + GROUP_N - 1) / GROUP_N;
    localparam int NG_W  = (NG > 1) ? $clog2(NG) : 1;
    localparam int LOC_W = $clog2(GROUP_N);
    localparam int PAD_W = NG * GROUP_N;
    localparam int CAT_W = NG_W + LOC_W;

    logic [PAD_W-1:0] w_pad;
    logic [NG-1:0]    r_any;
    logic [NG-1:0]    n_any;
    logic [LOC_W-1:0] r_loc [NG];
    logic [LOC_W-1:0] n_loc [NG];
    logic [NG_W-1:0]  w_grp;
    logic [CAT_W-1:0] w_cat;
    logic             r_found;
    logic [IDX_W-1:0] r_index;

    assign w_pad = PAD_W'(i_match);

    // first stage: lowest set bit inside each group
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_any[g] = |w_pad[g*GROUP_N +: GROUP_N];
            n_loc[g] = '0;
            for (int b = GROUP_N - 1; b >= 0; b--) begin
                if (w_pad[g*GROUP_N + b]) begin
                    n_loc[g] = LOC_W'(b);
                end
            end
        end
    end

    // second stage: lowest group with a hit
    always_comb begin
        w_grp = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_any[g]) begin
                w_grp = NG_W'(g);
            end
        end
    end

    assign w_cat = {w_grp, r_loc[w_grp]};

    always_ff @(posedge i_clk) begin
        r_any   <= n_any;
        r_loc   <= n_loc;
        r_found <= |r_any;
        r_index <= w_cat[IDX_W-1:0];
    end

    assign o_found = r_found;
    assign o_index = r_index;

endmodule

>>> rtl/isa_ctrl.sv
`timescale 1ns / 1ps
module isa_ctrl #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  isa_pkg::t_op           i_op,
    input  logic [4:0]             i_pos,
    input  logic [31:0]            i_val,
    input  logic [VALUE_WIDTH-1:0] i_data [DEPTH],
    input  logic                   i_found,
    input  logic [IDX_W-1:0]       i_fidx,
    output logic [DEPTH-1:0]       o_live,
    output isa_pkg::t_cell_op      o_cell_op,
    output logic [IDX_W-1:0]       o_cell_pos,
    output logic [VALUE_WIDTH-1:0] o_key,
    output logic                   o_ovalid,
    input  logic                   i_oready,
    output isa_pkg::t_result       o_result
);
    import isa_pkg::*;

    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    t_state                 r_state;
    t_state                 n_state;
    t_op                    r_op;
    logic [4:0]             r_pos;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic                   r_ovalid;
    t_result                r_res;

    logic [63:0]            w_nv64;
    logic [CMP_W-1:0]       w_pos_u;
    logic [CMP_W-1:0]       w_cnt_u;
    logic [CMP_W-1:0]       w_fidx_u;
    logic                   w_inrange;
    logic [IDX_W-1:0]       w_pidx;
    logic [CNT_W-1:0]       w_cnt_m1;
    logic [IDX_W-1:0]       w_rd_addr;
    logic [VALUE_WIDTH-1:0] w_rd_val;
    logic                   w_out_free;
    logic                   w_search;
    logic                   w_full;
    logic                   w_load;
    logic [VALUE_WIDTH-1:0] w_rv;
    logic [63:0]            w_rv64;
    logic [3:0]             w_ri;
    t_status                w_st;
    logic [CMP_W-1:0]       w_tot_u;

    assign w_nv64     = 64'(i_val);
    assign w_pos_u    = CMP_W'(r_pos[3:0]);
    assign w_cnt_u    = CMP_W'(r_cnt);
    assign w_fidx_u   = CMP_W'(i_fidx);
    assign w_inrange  = !r_pos[4] && (w_pos_u < w_cnt_u);
    assign w_pidx     = w_pos_u[IDX_W-1:0];
    assign w_cnt_m1   = r_cnt - CNT_W'(1);
    assign w_rd_addr  = (r_op == OP_POP) ? w_cnt_m1[IDX_W-1:0] : w_pidx;
    assign w_rd_val   = i_data[w_rd_addr];
    assign w_out_free = !r_ovalid || i_oready;
    assign w_search   = (r_op == OP_FIND) || (r_op == OP_REMOVE_VAL);
    assign w_full     = (r_cnt >= CNT_W'(DEPTH));

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            o_live[i] = (CNT_W'(i) < r_cnt);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_search) begin
                    n_state = ST_SRCH;
                end else if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SRCH: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs: cell command, count update and result
    always_comb begin
        o_cell_op  = CELL_HOLD;
        o_cell_pos = '0;
        n_cnt      = r_cnt;
        w_load     = 1'b0;
        w_rv       = '0;
        w_ri       = '0;
        w_st       = STS_OK;
        unique case (r_state)
            ST_EXEC: begin
                if (!w_search && w_out_free) begin
                    w_load = 1'b1;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (w_full) begin
                                w_st = STS_FULL;
                            end else begin
                                o_cell_op  = CELL_INS;
                                o_cell_pos = w_inrange ? w_pidx : r_cnt[IDX_W-1:0];
                                n_cnt      = r_cnt + CNT_W'(1);
                                w_rv       = r_key;
                            end
                        end
                        OP_REMOVE_AT: begin
                            if (!w_inrange) begin
                                w_st = STS_RANGE;
                            end else begin
                                o_cell_op  = CELL_DEL;
                                o_cell_pos = w_pidx;
                                n_cnt      = w_cnt_m1;
                                w_rv       = w_rd_val;
                            end
                        end
                        OP_READ: begin
                            if (!w_inrange) begin
                                w_st = STS_RANGE;
                            end else begin
                                w_rv = w_rd_val;
                            end
                        end
                        OP_WRITE: begin
                            if (!w_inrange) begin
                                w_st = STS_RANGE;
                            end else begin
                                o_cell_op  = CELL_WR;
                                o_cell_pos = w_pidx;
                                w_rv       = r_key;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt = '0;
                        end
                        OP_POP: begin
                            if (r_cnt == '0) begin
                                w_st = STS_EMPTY;
                            end else begin
                                n_cnt = w_cnt_m1;
                                w_rv  = w_rd_val;
                            end
                        end
                        default: begin
                            w_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    if (!i_found) begin
                        w_st = STS_MISSING;
                    end else begin
                        // a hit holds the key itself
                        w_rv = r_key;
                        if (r_op == OP_FIND) begin
                            w_ri = w_fidx_u[3:0];
                        end else begin
                            o_cell_op  = CELL_DEL;
                            o_cell_pos = i_fidx;
                            n_cnt      = w_cnt_m1;
                        end
                    end
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    assign w_rv64  = 64'(w_rv);
    assign w_tot_u = CMP_W'(n_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_oready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_op  <= i_op;
            r_pos <= i_pos;
            r_key <= w_nv64[VALUE_WIDTH-1:0];
        end
        if (w_load) begin
            r_res.value  <= w_rv64[31:0];
            r_res.index  <= w_ri;
            r_res.total  <= w_tot_u[4:0];
            r_res.status <= w_st;
        end
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign o_key    = r_key;
    assign o_ovalid = r_ovalid;
    assign o_result = r_res;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("live count above depth");

    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_state == ST_EXEC || r_state == ST_FIN))
        else $error("result loaded outside execute or finish");

    a_cnt_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_cnt)) |-> $past(w_load))
        else $error("count changed without a result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_res.status != STS_OK) |-> (r_res.value == '0 && r_res.index == '0))
        else $error("error result carries data");

    a_search_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH) |-> (r_op == OP_FIND || r_op == OP_REMOVE_VAL))
        else $error("search entered for a positional operation");

endmodule
